/* src/sbib_pkg.sv */
`default_nettype none
package sbib_pkg;

  localparam int STORE_WIDTH_DEF  = 256;
  localparam int STORE_HEIGHT_DEF = 256;

  localparam int POS_W   = 12;
  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int RATIO_W = 9;
  localparam int STEP_W  = 17;
  localparam int LAST_W  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;
  localparam int SCALED_W = POS_W + STEP_W;
  localparam int OFF_W    = 24;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_BLEND = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_RATIO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_COL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_ROW    = 3'd4;

  // (a * (65536 - f) + b * f) >> 16, a and b 8 bits
  function automatic logic [CH_W-1:0] lerp16(input logic [CH_W-1:0] a,
                                             input logic [CH_W-1:0] b,
                                             input logic [15:0] f);
    logic [24:0] acc;
    acc = 25'(a) * 25'(17'h10000 - 17'(f)) + 25'(b) * 25'(f);
    return acc[23:16];
  endfunction

endpackage
`default_nettype wire

/* src/scaled_bilinear_image_blend_unit.sv */
// The result reaches the output register after eight register stages,
// the first loaded at the accepting edge.
// Throughput: one request per cycle unless stalled; load requests give no result.
// The four bilinear neighbours are read at once from four row/column parity banks.
// Reset (rst, synchronous) clears valid bits and loads configuration defaults;
// the pixel store is not cleared and holds garbage until loaded.
`default_nettype none
module scaled_bilinear_image_blend_unit import sbib_pkg::*; #(
  parameter int STORE_WIDTH  = STORE_WIDTH_DEF,
  parameter int STORE_HEIGHT = STORE_HEIGHT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [47:0]           s_axis_tdata,  // pos_x, pos_y, blue, green, red
  input  wire logic [0:0]            s_axis_tuser,  // req_type
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [23:0]                m_axis_tdata,  // out_blue, out_green, out_red
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int WB  = (STORE_WIDTH + 1) / 2;
  localparam int HB  = (STORE_HEIGHT + 1) / 2;
  localparam int BD  = WB * HB;
  localparam int BAW = (BD > 1) ? $clog2(BD) : 1;

  // configuration
  logic [RATIO_W-1:0] blend_ratio;
  logic [STEP_W-1:0]  x_step, y_step;
  logic [LAST_W-1:0]  store_last_col, store_last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_ratio    <= 9'd128;
      x_step         <= 17'h10000;
      y_step         <= 17'h10000;
      store_last_col <= 8'd255;
      store_last_row <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLEND_RATIO: blend_ratio    <= cfg_data[RATIO_W-1:0];
        CFG_X_STEP:      x_step         <= cfg_data[STEP_W-1:0];
        CFG_Y_STEP:      y_step         <= cfg_data[STEP_W-1:0];
        CFG_LAST_COL:    store_last_col <= cfg_data[LAST_W-1:0];
        CFG_LAST_ROW:    store_last_row <= cfg_data[LAST_W-1:0];
        default: ;
      endcase
    end
  end

  logic [POS_W-1:0] lastc, lastr;
  logic [RATIO_W-1:0] ratio;
  assign lastc = (POS_W'(store_last_col) > POS_W'(STORE_WIDTH - 1)) ?
                 POS_W'(STORE_WIDTH - 1) : POS_W'(store_last_col);
  assign lastr = (POS_W'(store_last_row) > POS_W'(STORE_HEIGHT - 1)) ?
                 POS_W'(STORE_HEIGHT - 1) : POS_W'(store_last_row);
  assign ratio = (blend_ratio > 9'd256) ? 9'd256 : blend_ratio;

  function automatic logic [CH_W-1:0] mix_ch(input logic [CH_W-1:0] a,
                                             input logic [CH_W-1:0] s);
    logic [16:0] acc;
    acc = 17'(a) * 17'(ratio) + 17'(s) * 17'(9'd256 - ratio);
    return acc[15:8];
  endfunction

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic v1, v2, v3, v4, v5, v6, v7, v8;

  // stage 1: input register
  logic t1; logic [POS_W-1:0] px1, py1; logic [PIX_W-1:0] ch1;
  // stage 2: scaled positions
  logic t2; logic [POS_W-1:0] px2, py2; logic [PIX_W-1:0] ch2;
  logic [SCALED_W-1:0] sx2, sy2; logic in2;
  // stage 3: clamped neighbours
  logic t3, ok3; logic [PIX_W-1:0] ch3;
  logic [POS_W-1:0] c0_3, c1_3, r0_3, r1_3; logic [15:0] fx3, fy3;
  // stage 4: row offsets
  logic t4, ok4; logic [PIX_W-1:0] ch4; logic [15:0] fx4, fy4;
  logic [OFF_W-1:0] ro0_4, ro1_4; logic [POS_W-2:0] ch0_4, ch1_4;
  logic c0p4, c1p4, r0p4, r1p4;
  // stage 5: bank read data
  logic t5; logic [PIX_W-1:0] ch5; logic [15:0] fx5, fy5;
  logic c0p5, c1p5, r0p5, r1p5;
  logic [3:0][PIX_W-1:0] rd5;
  // stage 6: vertical blend
  logic t6; logic [PIX_W-1:0] ch6; logic [15:0] fx6;
  logic [2:0][CH_W-1:0] lft6, rgt6;
  // stage 7: sample
  logic t7; logic [PIX_W-1:0] ch7; logic [2:0][CH_W-1:0] smp7;
  // stage 8: output
  logic [2:0][CH_W-1:0] out8;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8} <= '0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7 && (t7 == REQ_BLEND);
    end
  end

  logic [POS_W:0] c0w, r0w;
  logic [POS_W-1:0] c0n, r0n, c1n, r1n;
  always_comb begin
    c0w = sx2[SCALED_W-1:16];
    r0w = sy2[SCALED_W-1:16];
    c0n = (c0w > {1'b0, lastc}) ? lastc : c0w[POS_W-1:0];
    r0n = (r0w > {1'b0, lastr}) ? lastr : r0w[POS_W-1:0];
    c1n = (c0n >= lastc) ? lastc : c0n + 1'b1;
    r1n = (r0n >= lastr) ? lastr : r0n + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1  <= s_axis_tuser[0];
      px1 <= s_axis_tdata[11:0];
      py1 <= s_axis_tdata[23:12];
      ch1 <= s_axis_tdata[47:24];

      t2  <= t1;
      px2 <= px1;
      py2 <= py1;
      ch2 <= ch1;
      sx2 <= SCALED_W'(px1) * SCALED_W'(x_step);
      sy2 <= SCALED_W'(py1) * SCALED_W'(y_step);
      in2 <= ({1'b0, px1} < (POS_W + 1)'(STORE_WIDTH)) &&
             ({1'b0, py1} < (POS_W + 1)'(STORE_HEIGHT));

      t3  <= t2;
      ok3 <= in2;
      ch3 <= ch2;
      fx3 <= sx2[15:0];
      fy3 <= sy2[15:0];
      if (t2 == REQ_LOAD) begin
        c0_3 <= px2; c1_3 <= px2; r0_3 <= py2; r1_3 <= py2;
      end else begin
        c0_3 <= c0n; c1_3 <= c1n; r0_3 <= r0n; r1_3 <= r1n;
      end

      t4    <= t3;
      ok4   <= ok3;
      ch4   <= ch3;
      fx4   <= fx3;
      fy4   <= fy3;
      ro0_4 <= OFF_W'(r0_3[POS_W-1:1]) * OFF_W'(WB);
      ro1_4 <= OFF_W'(r1_3[POS_W-1:1]) * OFF_W'(WB);
      ch0_4 <= c0_3[POS_W-1:1];
      ch1_4 <= c1_3[POS_W-1:1];
      c0p4  <= c0_3[0];
      c1p4  <= c1_3[0];
      r0p4  <= r0_3[0];
      r1p4  <= r1_3[0];

      t5   <= t4;
      ch5  <= ch4;
      fx5  <= fx4;
      fy5  <= fy4;
      c0p5 <= c0p4;
      c1p5 <= c1p4;
      r0p5 <= r0p4;
      r1p5 <= r1p4;
    end
  end

  // parity banks: entry (c, r) lives in bank {r[0], c[0]}
  logic [3:0] bank_we;
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic [1:0] BSEL = 2'(b);
    logic [PIX_W-1:0] mem [BD];
    logic [OFF_W-1:0] addr_full;
    logic [BAW-1:0]   addr;
    assign addr_full = ((r0p4 == BSEL[1]) ? ro0_4 : ro1_4) +
                       OFF_W'((c0p4 == BSEL[0]) ? ch0_4 : ch1_4);
    assign addr = addr_full[BAW-1:0];
    assign bank_we[b] = en && v4 && (t4 == REQ_LOAD) && ok4 &&
                        ({r0p4, c0p4} == BSEL);
    always_ff @(posedge clk) begin
      if (bank_we[b]) mem[addr] <= ch4;
      if (en) rd5[b] <= mem[addr];
    end
  end

  logic [3:0][PIX_W-1:0] nb;  // c0r0, c0r1, c1r0, c1r1
  always_comb begin
    nb[0] = rd5[{r0p5, c0p5}];
    nb[1] = rd5[{r1p5, c0p5}];
    nb[2] = rd5[{r0p5, c1p5}];
    nb[3] = rd5[{r1p5, c1p5}];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t6  <= t5;
      ch6 <= ch5;
      fx6 <= fx5;
      for (int k = 0; k < 3; k++) begin
        lft6[k] <= lerp16(nb[0][k*CH_W +: CH_W], nb[1][k*CH_W +: CH_W], fy5);
        rgt6[k] <= lerp16(nb[2][k*CH_W +: CH_W], nb[3][k*CH_W +: CH_W], fy5);
      end

      t7  <= t6;
      ch7 <= ch6;
      for (int k = 0; k < 3; k++) begin
        smp7[k] <= lerp16(lft6[k], rgt6[k], fx6);
      end

      for (int k = 0; k < 3; k++) begin
        out8[k] <= mix_ch(ch7[k*CH_W +: CH_W], smp7[k]);
      end
    end
  end

  assign m_axis_tvalid = v8;
  assign m_axis_tdata  = out8;

`ifndef SYNTHESIS
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    en && v7 && (t7 == REQ_LOAD) |=> !m_axis_tvalid)
    else $error("load request produced a result");

  a_one_bank_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0(bank_we))
    else $error("more than one bank written");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (bank_we != 4'd0) |-> (g_bank[0].addr_full < OFF_W'(BD)) ||
                          (g_bank[1].addr_full < OFF_W'(BD)))
    else $error("store write beyond bank depth");

  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(rd5) && $stable(out8))
    else $error("pipeline data changed during stall");
`endif

endmodule
`default_nettype wire

/* verif/scaled_bilinear_image_blend_unit_tb.sv */
`default_nettype none
module scaled_bilinear_image_blend_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sbib_pkg::*;

  typedef struct packed {
    logic            kind;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] r;
  } pix_req_t;

  // blue in the lowest bits, as on the result bus
  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } bgr_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // pos_x, pos_y, blue, green, red
  logic [0:0] s_axis_tuser = '0;    // req_type
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // out_blue, out_green, out_red
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  scaled_bilinear_image_blend_unit i_dut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the image store and registers
  logic [PIX_W-1:0] img_mem [0:65535];
  int unsigned ratio_q8 = 128, xstep_q16 = 65536, ystep_q16 = 65536;
  int unsigned last_col = 255, last_row = 255;

  pix_req_t pending_reqs[$];
  bgr_t blended_q[$];
  int unsigned n_pushed = 0, n_loads = 0, n_blends = 0, n_results = 0;
  int unsigned n_errors = 0, n_phases = 0;
  bit calm = 1'b0;
  logic hold_off = 1'b0;

  function automatic int unsigned lerp_ch(int unsigned a, int unsigned b, int unsigned f);
    return (a * (65536 - f) + b * f) >> 16;
  endfunction

  function automatic bgr_t blend_pixel(pix_req_t q);
    int unsigned sx, sy, fx, fy, c0, c1, r0, r1, rat, lt, rt, smp, ch, sh;
    logic [PIX_W-1:0] p00, p01, p10, p11;
    bgr_t res;
    sx = q.x * xstep_q16;
    sy = q.y * ystep_q16;
    fx = sx & 16'hFFFF;
    fy = sy & 16'hFFFF;
    c0 = (sx >> 16) > last_col ? last_col : sx >> 16;
    r0 = (sy >> 16) > last_row ? last_row : sy >> 16;
    c1 = c0 + 1 > last_col ? last_col : c0 + 1;
    r1 = r0 + 1 > last_row ? last_row : r0 + 1;
    rat = ratio_q8 > 256 ? 256 : ratio_q8;
    p00 = img_mem[r0 * 256 + c0];
    p01 = img_mem[r1 * 256 + c0];
    p10 = img_mem[r0 * 256 + c1];
    p11 = img_mem[r1 * 256 + c1];
    for (int k = 0; k < 3; k++) begin
      sh = 8 * k;
      lt = lerp_ch((p00 >> sh) & 8'hFF, (p01 >> sh) & 8'hFF, fy);
      rt = lerp_ch((p10 >> sh) & 8'hFF, (p11 >> sh) & 8'hFF, fy);
      smp = lerp_ch(lt, rt, fx);
      ch = k == 0 ? q.b : (k == 1 ? q.g : q.r);
      ch = (ch * rat + smp * (256 - rat)) >> 8;
      if (k == 0) res.b = ch[7:0];
      else if (k == 1) res.g = ch[7:0];
      else res.r = ch[7:0];
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  pix_req_t cur;
  bit have_cur = 1'b0;
  int unsigned src_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (cur.kind == REQ_LOAD) begin
          n_loads++;
          if (cur.x < 256 && cur.y < 256) img_mem[cur.y * 256 + cur.x] = {cur.r, cur.g, cur.b};
        end else begin
          n_blends++;
          blended_q.push_back(blend_pixel(cur));
        end
        have_cur = 1'b0;
        src_gap = pick_gap();
      end
      if (!have_cur) begin
        if (src_gap > 0) src_gap--;
        else if (pending_reqs.size() > 0) begin
          cur = pending_reqs.pop_front();
          have_cur = 1'b1;
        end
      end
      s_axis_tvalid <= have_cur;
      s_axis_tdata <= {cur.r, cur.g, cur.b, cur.y, cur.x};
      s_axis_tuser <= cur.kind;
    end
  end

  // monitor
  int unsigned sink_gap = 0;
  always @(posedge clk) begin
    bgr_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        n_results++;
        if (blended_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = blended_q.pop_front();
          if (got.b !== want.b || got.g !== want.g || got.r !== want.r) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch: expected b=%h g=%h r=%h, got b=%h g=%h r=%h",
                       want.b, want.g, want.r, got.b, got.g, got.r);
          end
        end
        sink_gap = pick_gap();
      end else if (sink_gap > 0) begin
        sink_gap--;
      end
      m_axis_tready <= !hold_off && sink_gap == 0;
    end
  end

  // long receiver stall once the run is well under way
  initial begin
    wait (n_pushed >= 700);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic push_req(logic kind, int unsigned x, int unsigned y, logic [23:0] px);
    pix_req_t q;
    q.kind = kind;
    q.x = x[11:0];
    q.y = y[11:0];
    {q.r, q.g, q.b} = px;
    pending_reqs.push_back(q);
    n_pushed++;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || have_cur || blended_q.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_regs(int unsigned rat, int unsigned xs, int unsigned ys,
                          int unsigned lc, int unsigned lr);
    logic [CFG_IDX_W-1:0] idx [5];
    int unsigned val [5];
    idx = '{CFG_BLEND_RATIO, CFG_X_STEP, CFG_Y_STEP, CFG_LAST_COL, CFG_LAST_ROW};
    val = '{rat, xs, ys, lc, lr};
    for (int i = 0; i < 5; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i][CFG_DATA_W-1:0];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    ratio_q8 = rat & 9'h1FF;
    xstep_q16 = xs & 17'h1FFFF;
    ystep_q16 = ys & 17'h1FFFF;
    last_col = lc & 8'hFF;
    last_row = lr & 8'hFF;
    n_phases++;
  endtask

  // fills the stored region that blends of this setting can touch
  task automatic load_region(bit extremes);
    for (int r = 0; r <= int'(last_row); r++)
      for (int c = 0; c <= int'(last_col); c++)
        push_req(REQ_LOAD, c, r, extremes ? (((r + c) % 2) ? 24'hFFFFFF : 24'h000000)
                                          : 24'($urandom));
  endtask

  function automatic int unsigned rand_pos();
    return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4095);
  endfunction

  task automatic random_blends(int unsigned n);
    int unsigned k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 80)
        push_req(REQ_BLEND, rand_pos(), rand_pos(), 24'($urandom));
      else if (k < 90)
        push_req(REQ_LOAD, $urandom_range(0, last_col), $urandom_range(0, last_row),
                 24'($urandom));
      else
        push_req(REQ_LOAD, $urandom_range(256, 4095), $urandom_range(0, 4095),
                 24'($urandom));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extreme pixels, edge positions, ratio 0 and 256
    set_regs(0, 65536, 65536, 3, 3);
    load_region(1);
    push_req(REQ_BLEND, 0, 0, 24'hFFFFFF);
    push_req(REQ_BLEND, 4095, 4095, 24'h000000);
    push_req(REQ_BLEND, 2, 1, 24'hA5A5A5);
    push_req(REQ_LOAD, 4095, 4095, 24'h123456);
    push_req(REQ_LOAD, 255, 256, 24'h654321);
    drain();
    set_regs(256, 32768, 16384, 3, 3);
    push_req(REQ_BLEND, 3, 5, 24'hFFFFFF);
    push_req(REQ_BLEND, 4095, 0, 24'h000000);
    push_req(REQ_BLEND, 1, 3, 24'h00FF00);
    drain();
    // ratio saturates, zero x step, one stored row across the full width
    set_regs(511, 0, 65536, 255, 0);
    load_region(0);
    random_blends(40);
    drain();
    set_regs(128, 65535, 0, 0, 255);
    load_region(0);
    random_blends(40);
    drain();

    while (n_pushed < 1150) begin
      calm = (n_phases % 3) == 0;
      set_regs($urandom_range(0, 3) == 0 ? 256 : $urandom_range(0, 511),
               $urandom_range(0, 3) == 0 ? 65536 : $urandom_range(0, 131071),
               $urandom_range(0, 3) == 0 ? 65536 : $urandom_range(0, 131071),
               $urandom_range(0, 9), $urandom_range(0, 9));
      load_region(0);
      random_blends(100);
      drain();
    end
    calm = 1'b0;
    repeat (20) @(posedge clk);

    $display("%0d loads and %0d blends over %0d register settings, %0d results checked",
             n_loads, n_blends, n_phases, n_results);
    if (n_errors == 0 && blended_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire
